// ===== hdl/esc_pkg.sv =====
// shared types and constants for the export stream change detector
// no dependencies; imported by esc_value_table and the top level
`default_nettype none

package esc_pkg;

  localparam int unsigned WORD_W = 16;

  typedef logic [WORD_W-1:0] word_t;

  // value the table holds after the clearing pass
  localparam word_t TABLE_FILL = 16'hFFFF;

  // per-transfer requests from the parser to the value table
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

endpackage : esc_pkg

`default_nettype wire

// ===== hdl/esc_value_table.sv =====
// last-value table: single write port, one registered read port
// clears every entry to the fill value in a sweep after reset
// depends on esc_pkg
`default_nettype none

module esc_value_table
  import esc_pkg::*;
#(
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tbl_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0] rd_idx,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire word_t            wr_data,
  output word_t                 rd_data,
  output logic                  busy
);

  word_t            mem [DEPTH];
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == IDX_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= TABLE_FILL;
    end else if (ctrl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule : esc_value_table

`default_nettype wire

// ===== hdl/export_stream_change_detector.sv =====
// export stream change detector: parses an export byte stream, emits changed words
// each result is registered into the output register, or into the skid entry if the output stalls
// throughput: one byte per cycle while s_tready is high; the table read is issued on the low data byte
// reset: a clearing pass fills the table, s_tready low
// throughout; configuration writes are taken during the pass
// depends on esc_pkg and esc_value_table
`default_nettype none

module export_stream_change_detector
  import esc_pkg::*;
#(
  parameter int unsigned VALUE_TABLE_DEPTH = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_write_data,  // change_detect_enable
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,         // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,         // [14:0] change_address, [30:15] change_value
  output logic             m_tuser,         // change_valid
  output logic             m_tlast          // broadcast_request
);

  localparam int unsigned IDX_W   = $clog2(VALUE_TABLE_DEPTH);
  localparam int unsigned RECIP   = (1 << 24) / VALUE_TABLE_DEPTH;
  localparam int unsigned RECIP_W = 17;

  localparam logic [2:0] PH_WAIT    = 3'd0;
  localparam logic [2:0] PH_ADDR_LO = 3'd1;
  localparam logic [2:0] PH_ADDR_HI = 3'd2;
  localparam logic [2:0] PH_CNT_LO  = 3'd3;
  localparam logic [2:0] PH_CNT_HI  = 3'd4;
  localparam logic [2:0] PH_DATA_LO = 3'd5;
  localparam logic [2:0] PH_DATA_HI = 3'd6;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam word_t      ADDR_STOP = 16'h5555;
  localparam word_t      ADDR_LAST = 16'hFFFE;

  logic             cde;
  logic [2:0]       phase, phase_next;
  logic [1:0]       sync_run;
  word_t            word_address, word_address_next;
  word_t            words_left, words_left_next;
  logic [7:0]       lo_byte;
  logic             frame_changed;
  logic             first_word;
  logic [IDX_W-1:0] table_idx, table_idx_next;

  // (address / 2) mod depth, two stages off the current address
  logic [13:0]        v1;
  logic [6:0]         q1;
  logic [IDX_W-1:0]   idx_calc;
  logic [RECIP_W+13:0] recip_prod;
  logic [15:0]        rem_raw;

  logic       accept, sync_hit, emit, changed, low_addr;
  word_t      new_word, rd_data;
  tbl_ctrl_t  tctrl;
  logic       tbl_busy;
  logic       res_user, res_last;
  logic [31:0] res_data;

  logic        skid_valid, skid_user, skid_last;
  logic [31:0] skid_data;
  logic        out_fire;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !tbl_busy && !skid_valid;
  assign out_fire = m_tvalid && m_tready;

  assign recip_prod = (RECIP_W + 14)'(RECIP) * (RECIP_W + 14)'(word_address[14:1]);
  assign rem_raw    = 16'(v1) - 16'(15'(q1) * 15'(VALUE_TABLE_DEPTH));

  always_ff @(posedge clk) begin
    v1 <= word_address[14:1];
    q1 <= recip_prod[RECIP_W+13:24];
    if (rem_raw >= 16'(VALUE_TABLE_DEPTH)) begin
      idx_calc <= IDX_W'(rem_raw - 16'(VALUE_TABLE_DEPTH));
    end else begin
      idx_calc <= IDX_W'(rem_raw);
    end
  end

  assign new_word = {s_tdata, lo_byte};
  assign low_addr = !word_address[15];
  assign changed  = rd_data != new_word;
  assign sync_hit = (s_tdata == SYNC_BYTE) && (sync_run == 2'd3);

  always_comb begin
    phase_next        = phase;
    word_address_next = word_address;
    words_left_next   = words_left;
    table_idx_next    = table_idx;
    tctrl             = '0;
    emit              = 1'b0;
    unique case (phase)
      PH_ADDR_LO: begin
        word_address_next = {8'h00, s_tdata};
        phase_next        = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        word_address_next = {s_tdata, word_address[7:0]};
        phase_next = (word_address_next != ADDR_STOP) ? PH_CNT_LO : PH_WAIT;
      end
      PH_CNT_LO: begin
        words_left_next = {8'h00, s_tdata};
        phase_next      = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        words_left_next = {s_tdata, words_left[7:0]};
        phase_next      = PH_DATA_LO;
      end
      PH_DATA_LO: begin
        words_left_next = words_left - 1'b1;
        tctrl.rd_en     = accept;
        table_idx_next  = first_word ? idx_calc : table_idx;
        phase_next      = PH_DATA_HI;
      end
      PH_DATA_HI: begin
        words_left_next   = words_left - 1'b1;
        emit              = low_addr && (!cde || changed);
        tctrl.wr_en       = accept && low_addr && cde && changed;
        word_address_next = word_address + 16'd2;
        // address wraps back to zero or one, so the index goes back to zero
        if (word_address[15:1] == ADDR_LAST[15:1] ||
            table_idx == IDX_W'(VALUE_TABLE_DEPTH - 1)) begin
          table_idx_next = '0;
        end else begin
          table_idx_next = table_idx + 1'b1;
        end
        phase_next = (words_left_next == '0) ? PH_ADDR_LO : PH_DATA_LO;
      end
      default: phase_next = PH_WAIT;
    endcase
    if (sync_hit) begin
      phase_next = PH_ADDR_LO;
    end
  end

  esc_value_table #(
    .DEPTH (VALUE_TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tctrl),
    .rd_idx  (table_idx_next),
    .wr_idx  (table_idx),
    .wr_data (new_word),
    .rd_data (rd_data),
    .busy    (tbl_busy)
  );

  assign res_user = emit;
  assign res_last = sync_hit && (frame_changed || emit);
  assign res_data = emit ? {1'b0, new_word, word_address[14:0]} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cde           <= 1'b1;
      phase         <= PH_WAIT;
      sync_run      <= '0;
      word_address  <= '0;
      words_left    <= '0;
      frame_changed <= 1'b0;
      first_word    <= 1'b0;
      table_idx     <= '0;
    end else begin
      if (cfg_write_en) begin
        cde <= cfg_write_data;
      end
      if (accept) begin
        phase        <= phase_next;
        word_address <= word_address_next;
        words_left   <= words_left_next;
        table_idx    <= table_idx_next;
        if (phase == PH_ADDR_HI) begin
          first_word <= 1'b1;
        end else if (phase == PH_DATA_HI) begin
          first_word <= 1'b0;
        end
        if (sync_hit || s_tdata != SYNC_BYTE) begin
          sync_run <= '0;
        end else begin
          sync_run <= sync_run + 1'b1;
        end
        if (sync_hit) begin
          frame_changed <= 1'b0;
        end else if (emit) begin
          frame_changed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA_LO) begin
      lo_byte <= s_tdata;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && (res_user || res_last)) begin
      if (!m_tvalid || out_fire) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
        m_tlast <= skid_last;
      end
    end else if (accept && (res_user || res_last)) begin
      if (!m_tvalid || out_fire) begin
        m_tdata <= res_data;
        m_tuser <= res_user;
        m_tlast <= res_last;
      end else begin
        skid_data <= res_data;
        skid_user <= res_user;
        skid_last <= res_last;
      end
    end
  end

endmodule : export_stream_change_detector

`default_nettype wire
